### rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the maze carver
// Field widths, register indexes, direction codes and the result record.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  localparam int CountW   = 6;
  localparam int CoordW   = 5;
  localparam int DirW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  localparam logic [CountW-1:0] GRID_ROWS_RST = CountW'(20);
  localparam logic [CountW-1:0] GRID_COLS_RST = CountW'(20);
  localparam logic [CoordW-1:0] START_COL_RST = '0;
  localparam logic [CoordW-1:0] START_ROW_RST = '0;

  // direction of a draw, also the side of the cell that loses its wall
  localparam logic [DirW-1:0] DIR_UP    = 2'd0;
  localparam logic [DirW-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DirW-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DirW-1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1,
    CFG_START_COL = 2'd2,
    CFG_START_ROW = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] grid_rows;
    logic [CountW-1:0] grid_cols;
    logic [CoordW-1:0] start_col;
    logic [CoordW-1:0] start_row;
  } cfg_t;

  typedef struct packed {
    logic              carved;
    logic [CoordW-1:0] from_col;
    logic [CoordW-1:0] from_row;
    logic [DirW-1:0]   wall_side;
    logic              finished;
  } result_t;

endpackage

### rtl/mcd_if.sv
// ----------------------------------------------------------------------------
// mcd_if: request channels of the maze carver
// Draw channel into the block and carve-event channel out of it.
// ----------------------------------------------------------------------------
interface mcd_draw_if;
  logic                    valid;
  logic                    ready;
  logic [mcd_pkg::DirW-1:0] draw_dir;

  modport source (output valid, output draw_dir, input ready);
  modport sink   (input valid, input draw_dir, output ready);
endinterface

interface mcd_carve_if;
  logic                      valid;
  logic                      ready;
  logic                      carved;
  logic [mcd_pkg::CoordW-1:0] from_col;
  logic [mcd_pkg::CoordW-1:0] from_row;
  logic [mcd_pkg::DirW-1:0]   wall_side;
  logic                      finished;

  modport source (output valid, output carved, output from_col, output from_row,
                  output wall_side, output finished, input ready);
  modport sink   (input valid, input carved, input from_col, input from_row,
                  input wall_side, input finished, output ready);
endinterface

### rtl/mcd_visit_mem.sv
// ----------------------------------------------------------------------------
// mcd_visit_mem: visited-cell store
// One word per grid row, one bit per column. Two registered read ports,
// one bit-set write port, and a row-by-row clearing pass after reset.
// ----------------------------------------------------------------------------
module mcd_visit_mem #(
  parameter int MAX_ROWS = mcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcd_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_a_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0] rd_a_row_i,
  output logic [MAX_COLS-1:0]         rd_a_data_o,
  input  logic                        rd_b_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0] rd_b_row_i,
  output logic [MAX_COLS-1:0]         rd_b_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_ROWS)-1:0] wr_row_i,
  input  logic [$clog2(MAX_COLS)-1:0] wr_col_i,
  output logic                        clear_busy_o
);

  localparam int RW = $clog2(MAX_ROWS);

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_a_q, rd_b_q;
  logic [RW-1:0]       clr_row_q, clr_row_d;
  logic                clr_busy_q, clr_busy_d;

  always_comb begin
    clr_row_d  = clr_row_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_row_d = RW'(clr_row_q + RW'(1));
      if (clr_row_q == RW'(MAX_ROWS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_row_q  <= clr_row_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_row_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_row_i][wr_col_i] <= 1'b1;
    end
    if (rd_a_en_i) begin
      rd_a_q <= mem_q[rd_a_row_i];
    end
    if (rd_b_en_i) begin
      rd_b_q <= mem_q[rd_b_row_i];
    end
  end

  assign rd_a_data_o  = rd_a_q;
  assign rd_b_data_o  = rd_b_q;
  assign clear_busy_o = clr_busy_q;

endmodule

### rtl/mcd_stack_mem.sv
// ----------------------------------------------------------------------------
// mcd_stack_mem: path stack store
// Cell coordinates of the current search path, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module mcd_stack_mem #(
  parameter int MAX_ROWS = mcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcd_pkg::MAX_COLS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             we_i,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]             waddr_i,
  input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]     wdata_i,
  input  logic                                             re_i,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]             raddr_i,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]     rdata_o
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int CellW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

  logic [CellW-1:0] mem_q [Depth];
  logic [CellW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mcd_ctrl.sv
// ----------------------------------------------------------------------------
// mcd_ctrl: search sequencer of the maze carver
// Reads the three visited rows around a cell, derives its open neighbours,
// carves, pushes and pops, and hands one result per request.
// ----------------------------------------------------------------------------
module mcd_ctrl #(
  parameter int MAX_ROWS = mcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcd_pkg::MAX_COLS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  mcd_pkg::cfg_t                                cfg_i,
  input  logic                                         in_valid_i,
  input  logic [mcd_pkg::DirW-1:0]                     in_dir_i,
  output logic                                         take_o,
  input  logic                                         out_free_i,
  output logic                                         res_valid_o,
  output mcd_pkg::result_t                             res_o,
  input  logic                                         clear_busy_i,
  output logic                                         vm_rd_a_en_o,
  output logic [$clog2(MAX_ROWS)-1:0]                  vm_rd_a_row_o,
  input  logic [MAX_COLS-1:0]                          vm_rd_a_data_i,
  output logic                                         vm_rd_b_en_o,
  output logic [$clog2(MAX_ROWS)-1:0]                  vm_rd_b_row_o,
  input  logic [MAX_COLS-1:0]                          vm_rd_b_data_i,
  output logic                                         vm_we_o,
  output logic [$clog2(MAX_ROWS)-1:0]                  vm_wr_row_o,
  output logic [$clog2(MAX_COLS)-1:0]                  vm_wr_col_o,
  output logic                                         stk_we_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]         stk_waddr_o,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] stk_wdata_o,
  output logic                                         stk_re_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]         stk_raddr_o,
  input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] stk_rdata_i
);

  localparam int RW       = $clog2(MAX_ROWS);
  localparam int CW       = $clog2(MAX_COLS);
  localparam int CellW    = RW + CW;
  localparam int CellN    = MAX_ROWS * MAX_COLS;
  localparam int SAW      = $clog2(CellN);
  localparam int LvlW     = $clog2(CellN + 1);
  localparam int RowCntW  = $clog2(MAX_ROWS + 1);
  localparam int ColCntW  = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD2  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_LOAD = 4'b1000
  } state_e;

  // which cell is under evaluation
  typedef enum logic [1:0] {
    EV_FIRST = 2'd0,
    EV_TOP   = 2'd1,
    EV_NEW   = 2'd2
  } eval_e;

  state_e state_q, state_d;
  eval_e  kind_q, kind_d;

  logic [LvlW-1:0]          level_q, level_d;
  logic                     begun_q, begun_d;
  logic                     done_q, done_d;
  logic [mcd_pkg::DirW-1:0] dir_q, dir_d;
  logic [CellW-1:0]         cell_q, cell_d;
  logic [CellW-1:0]         top_q, top_d;
  logic [CellW-1:0]         prev_q, prev_d;
  logic [MAX_COLS-1:0]      up_q, up_d;

  logic [RowCntW-1:0] rows_eff;
  logic [ColCntW-1:0] cols_eff;
  logic [CellW-1:0]   start_cell;
  logic [CellW-1:0]   nb_cell;
  logic [3:0]         mask;

  function automatic logic [RW-1:0] row_up(input logic [RW-1:0] r);
    return (r == '0) ? r : RW'(r - RW'(1));
  endfunction

  function automatic logic [RW-1:0] row_dn(input logic [RW-1:0] r);
    return (r == RW'(MAX_ROWS - 1)) ? r : RW'(r + RW'(1));
  endfunction

  function automatic logic [CW-1:0] col_lf(input logic [CW-1:0] c);
    return (c == '0) ? c : CW'(c - CW'(1));
  endfunction

  function automatic logic [CW-1:0] col_rt(input logic [CW-1:0] c);
    return (c == CW'(MAX_COLS - 1)) ? c : CW'(c + CW'(1));
  endfunction

  function automatic logic [CellW-1:0] neighbour(input logic [CellW-1:0] pos,
                                                  input logic [mcd_pkg::DirW-1:0] dir);
    logic [RW-1:0] r;
    logic [CW-1:0] c;
    logic [CellW-1:0] n;
    r = pos[CellW-1:CW];
    c = pos[CW-1:0];
    case (dir)
      mcd_pkg::DIR_UP:    n = {row_up(r), c};
      mcd_pkg::DIR_RIGHT: n = {r, col_rt(c)};
      mcd_pkg::DIR_DOWN:  n = {row_dn(r), c};
      default:            n = {r, col_lf(c)};
    endcase
    return n;
  endfunction

  // open neighbours of a cell: inside the grid in force and not yet visited
  function automatic logic [3:0] open_mask(input logic [CellW-1:0] pos,
                                           input logic [MAX_COLS-1:0] up,
                                           input logic [MAX_COLS-1:0] mid,
                                           input logic [MAX_COLS-1:0] dn,
                                           input logic [RowCntW-1:0] rows,
                                           input logic [ColCntW-1:0] cols);
    logic [RW-1:0] r;
    logic [CW-1:0] c;
    logic          r_in, c_in;
    logic [3:0]    m;
    r    = pos[CellW-1:CW];
    c    = pos[CW-1:0];
    r_in = RowCntW'(r) < rows;
    c_in = ColCntW'(c) < cols;
    m[mcd_pkg::DIR_UP]    = (r != '0) && (RowCntW'(r) - RowCntW'(1) < rows) && c_in
                            && !up[c];
    m[mcd_pkg::DIR_RIGHT] = r_in && (ColCntW'(c) + ColCntW'(1) < cols) && !mid[col_rt(c)];
    m[mcd_pkg::DIR_DOWN]  = (RowCntW'(r) + RowCntW'(1) < rows) && c_in && !dn[c];
    m[mcd_pkg::DIR_LEFT]  = (c != '0) && r_in && (ColCntW'(c) - ColCntW'(1) < cols)
                            && !mid[col_lf(c)];
    return m;
  endfunction

  // effective grid size and clamped start cell
  always_comb begin
    if (cfg_i.grid_rows == '0) begin
      rows_eff = RowCntW'(1);
    end else if (32'(cfg_i.grid_rows) > MAX_ROWS) begin
      rows_eff = RowCntW'(MAX_ROWS);
    end else begin
      rows_eff = RowCntW'(cfg_i.grid_rows);
    end
    if (cfg_i.grid_cols == '0) begin
      cols_eff = ColCntW'(1);
    end else if (32'(cfg_i.grid_cols) > MAX_COLS) begin
      cols_eff = ColCntW'(MAX_COLS);
    end else begin
      cols_eff = ColCntW'(cfg_i.grid_cols);
    end
    start_cell[CellW-1:CW] = (32'(cfg_i.start_row) < 32'(rows_eff)) ?
                             RW'(cfg_i.start_row) : RW'(rows_eff - RowCntW'(1));
    start_cell[CW-1:0]     = (32'(cfg_i.start_col) < 32'(cols_eff)) ?
                             CW'(cfg_i.start_col) : CW'(cols_eff - ColCntW'(1));
  end

  assign mask    = open_mask(cell_q, up_q, vm_rd_a_data_i, vm_rd_b_data_i, rows_eff, cols_eff);
  assign nb_cell = neighbour(cell_q, dir_q);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    level_d = level_q;
    begun_d = begun_q;
    done_d  = done_q;
    dir_d   = dir_q;
    cell_d  = cell_q;
    top_d   = top_q;
    prev_d  = prev_q;
    up_d    = up_q;

    take_o        = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    vm_rd_a_en_o  = 1'b0;
    vm_rd_a_row_o = '0;
    vm_rd_b_en_o  = 1'b0;
    vm_rd_b_row_o = '0;
    vm_we_o       = 1'b0;
    vm_wr_row_o   = nb_cell[CellW-1:CW];
    vm_wr_col_o   = nb_cell[CW-1:0];
    stk_we_o      = 1'b0;
    stk_waddr_o   = level_q[SAW-1:0];
    stk_wdata_o   = nb_cell;
    stk_re_o      = 1'b0;
    stk_raddr_o   = SAW'(level_q - LvlW'(2));

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && out_free_i && !clear_busy_i) begin
          take_o = 1'b1;
          dir_d  = in_dir_i;
          if (done_q) begin
            res_valid_o    = 1'b1;
            res_o.finished = 1'b1;
          end else if (!begun_q) begin
            begun_d       = 1'b1;
            vm_we_o       = 1'b1;
            vm_wr_row_o   = start_cell[CellW-1:CW];
            vm_wr_col_o   = start_cell[CW-1:0];
            stk_we_o      = 1'b1;
            stk_wdata_o   = start_cell;
            level_d       = LvlW'(level_q + LvlW'(1));
            top_d         = start_cell;
            cell_d        = start_cell;
            vm_rd_a_en_o  = 1'b1;
            vm_rd_a_row_o = row_up(start_cell[CellW-1:CW]);
            vm_rd_b_en_o  = 1'b1;
            vm_rd_b_row_o = row_dn(start_cell[CellW-1:CW]);
            kind_d        = EV_FIRST;
            state_d       = ST_RD2;
          end else begin
            cell_d        = top_q;
            vm_rd_a_en_o  = 1'b1;
            vm_rd_a_row_o = row_up(top_q[CellW-1:CW]);
            vm_rd_b_en_o  = 1'b1;
            vm_rd_b_row_o = row_dn(top_q[CellW-1:CW]);
            kind_d        = EV_TOP;
            state_d       = ST_RD2;
          end
        end
      end

      ST_RD2: begin
        // the row above is back; fetch the cell's own row
        up_d          = vm_rd_a_data_i;
        vm_rd_a_en_o  = 1'b1;
        vm_rd_a_row_o = cell_q[CellW-1:CW];
        state_d       = ST_EVAL;
      end

      ST_EVAL: begin
        case (kind_q)
          EV_FIRST: begin
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
            if (mask == '0) begin
              level_d        = LvlW'(level_q - LvlW'(1));
              done_d         = 1'b1;
              res_o.finished = 1'b1;
            end
          end
          EV_TOP: begin
            if (mask == '0) begin
              res_valid_o = 1'b1;
              level_d     = LvlW'(level_q - LvlW'(1));
              if (level_q == LvlW'(1)) begin
                done_d         = 1'b1;
                res_o.finished = 1'b1;
                state_d        = ST_IDLE;
              end else begin
                // fetch the cell below the popped one
                stk_re_o = 1'b1;
                state_d  = ST_LOAD;
              end
            end else if (mask[dir_q]) begin
              vm_we_o       = 1'b1;
              stk_we_o      = 1'b1;
              level_d       = LvlW'(level_q + LvlW'(1));
              prev_d        = top_q;
              top_d         = nb_cell;
              cell_d        = nb_cell;
              vm_rd_a_en_o  = 1'b1;
              vm_rd_a_row_o = row_up(nb_cell[CellW-1:CW]);
              vm_rd_b_en_o  = 1'b1;
              vm_rd_b_row_o = row_dn(nb_cell[CellW-1:CW]);
              kind_d        = EV_NEW;
              state_d       = ST_RD2;
            end else begin
              res_valid_o = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          EV_NEW: begin
            res_valid_o     = 1'b1;
            res_o.carved    = 1'b1;
            res_o.from_col  = mcd_pkg::CoordW'(prev_q[CW-1:0]);
            res_o.from_row  = mcd_pkg::CoordW'(prev_q[CellW-1:CW]);
            res_o.wall_side = dir_q;
            state_d         = ST_IDLE;
            // dead end: drop back to the cell it was carved from
            if (mask == '0) begin
              level_d = LvlW'(level_q - LvlW'(1));
              top_d   = prev_q;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_LOAD: begin
        top_d   = stk_rdata_i;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= EV_FIRST;
      level_q <= '0;
      begun_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      level_q <= level_d;
      begun_q <= begun_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    cell_q <= cell_d;
    top_q  <= top_d;
    prev_q <= prev_d;
    up_q   <= up_d;
  end

endmodule

### rtl/maze_carve_dfs.sv
// ----------------------------------------------------------------------------
// maze_carve_dfs: randomized depth-first maze carver
// Takes one direction draw per request and returns one carve event.
// ----------------------------------------------------------------------------
// Usage:
//   draw_i carries 2-bit direction draws; carve_o returns exactly one event
//   per draw, in order: carved flag, cell and side of the removed wall, and
//   the finished flag. Grid size and start cell are written through the
//   cfg port while the block is idle; the start is read on the first draw.
//   A draw after the maze is finished is answered straight from idle; the
//   first draw and draws that carve nothing read and evaluate one cell,
//   a carve evaluates the top cell and then the new one, and a pop that
//   leaves cells on the path adds a path-stack read. The rate is set by
//   the visited store: each cell needs three row words and the store has
//   two read ports. After reset a clearing pass wipes the visited store,
//   one row per cycle; draws are not taken until it ends, cfg writes are.
//   One draw waits in an input register while another is worked on; a
//   result waits in the output register while the receiver stalls, and the
//   next draw is not started until that register frees.
// ----------------------------------------------------------------------------
module maze_carve_dfs #(
  parameter int MAX_ROWS = mcd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mcd_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mcd_pkg::CfgDataW-1:0]  cfg_data_i,
  mcd_draw_if.sink                      draw_i,
  mcd_carve_if.source                   carve_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CellW = RW + CW;
  localparam int SAW   = $clog2(MAX_ROWS * MAX_COLS);

  mcd_pkg::cfg_t    cfg_q, cfg_d;
  mcd_pkg::result_t out_q, res;
  logic             out_valid_q, out_valid_d;
  logic             in_valid_q, in_valid_d;
  logic [mcd_pkg::DirW-1:0] in_dir_q;

  logic             take, res_valid, out_free, clear_busy, accept;
  logic             vm_rd_a_en, vm_rd_b_en, vm_we;
  logic [RW-1:0]    vm_rd_a_row, vm_rd_b_row, vm_wr_row;
  logic [CW-1:0]    vm_wr_col;
  logic [MAX_COLS-1:0] vm_rd_a_data, vm_rd_b_data;
  logic             stk_we, stk_re;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [CellW-1:0] stk_wdata, stk_rdata;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mcd_pkg::cfg_idx_e'(cfg_idx_i))
        mcd_pkg::CFG_GRID_ROWS: cfg_d.grid_rows = cfg_data_i;
        mcd_pkg::CFG_GRID_COLS: cfg_d.grid_cols = cfg_data_i;
        mcd_pkg::CFG_START_COL: cfg_d.start_col = cfg_data_i[mcd_pkg::CoordW-1:0];
        mcd_pkg::CFG_START_ROW: cfg_d.start_row = cfg_data_i[mcd_pkg::CoordW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // input holding register
  assign draw_i.ready = !in_valid_q && !clear_busy;
  assign accept       = draw_i.valid && draw_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (take) begin
      in_valid_d = 1'b0;
    end
  end

  // output register
  assign out_free = !out_valid_q || carve_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (carve_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_rows <= mcd_pkg::GRID_ROWS_RST;
      cfg_q.grid_cols <= mcd_pkg::GRID_COLS_RST;
      cfg_q.start_col <= mcd_pkg::START_COL_RST;
      cfg_q.start_row <= mcd_pkg::START_ROW_RST;
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_dir_q <= draw_i.draw_dir;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign carve_o.valid     = out_valid_q;
  assign carve_o.carved    = out_q.carved;
  assign carve_o.from_col  = out_q.from_col;
  assign carve_o.from_row  = out_q.from_row;
  assign carve_o.wall_side = out_q.wall_side;
  assign carve_o.finished  = out_q.finished;

  mcd_visit_mem #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_visit_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_a_en_i    (vm_rd_a_en),
    .rd_a_row_i   (vm_rd_a_row),
    .rd_a_data_o  (vm_rd_a_data),
    .rd_b_en_i    (vm_rd_b_en),
    .rd_b_row_i   (vm_rd_b_row),
    .rd_b_data_o  (vm_rd_b_data),
    .wr_en_i      (vm_we),
    .wr_row_i     (vm_wr_row),
    .wr_col_i     (vm_wr_col),
    .clear_busy_o (clear_busy)
  );

  mcd_stack_mem #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  mcd_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_q),
    .in_dir_i       (in_dir_q),
    .take_o         (take),
    .out_free_i     (out_free),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .clear_busy_i   (clear_busy),
    .vm_rd_a_en_o   (vm_rd_a_en),
    .vm_rd_a_row_o  (vm_rd_a_row),
    .vm_rd_a_data_i (vm_rd_a_data),
    .vm_rd_b_en_o   (vm_rd_b_en),
    .vm_rd_b_row_o  (vm_rd_b_row),
    .vm_rd_b_data_i (vm_rd_b_data),
    .vm_we_o        (vm_we),
    .vm_wr_row_o    (vm_wr_row),
    .vm_wr_col_o    (vm_wr_col),
    .stk_we_o       (stk_we),
    .stk_waddr_o    (stk_waddr),
    .stk_wdata_o    (stk_wdata),
    .stk_re_o       (stk_re),
    .stk_raddr_o    (stk_raddr),
    .stk_rdata_i    (stk_rdata)
  );

endmodule

### rtl/mcd_checker.sv
// ----------------------------------------------------------------------------
// mcd_checker: port-level checks of the maze carver
// Watches the carve-event channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mcd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  mcd_carve_if.source carve_o
);

  logic seen_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fin_q <= 1'b0;
    end else if (carve_o.valid && carve_o.ready && carve_o.finished) begin
      seen_fin_q <= 1'b1;
    end
  end

  // a carve always leaves cells on the path
  a_carve_not_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve_o.valid && carve_o.carved |-> !carve_o.finished)
    else $error("carve reported together with finished");

  // events without a carve report no wall
  a_no_carve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve_o.valid && !carve_o.carved |->
      carve_o.from_col == '0 && carve_o.from_row == '0 && carve_o.wall_side == '0)
    else $error("wall fields set without a carve");

  // once finished, every later event stays finished and carves nothing
  a_finished_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve_o.valid && seen_fin_q |-> carve_o.finished && !carve_o.carved)
    else $error("event after finish is not a finished no-op");

  // a stalled event holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve_o.valid && !carve_o.ready |=> carve_o.valid
      && $stable(carve_o.carved) && $stable(carve_o.from_col)
      && $stable(carve_o.from_row) && $stable(carve_o.wall_side)
      && $stable(carve_o.finished))
    else $error("stalled carve event changed");

endmodule

bind maze_carve_dfs mcd_checker u_mcd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .carve_o (carve_o)
);
